// ===== sv/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// shared types and constants of the msb-first bit packer
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int VALUE_BITS     = 32;
    localparam int PEND_BITS      = 7;
    localparam int ACC_BITS       = PEND_BITS + VALUE_BITS;
    localparam int MAX_BEATS      = 4;
    localparam int WORD_BITS      = 8 * MAX_BEATS;
    localparam int COUNT_BITS     = 6;
    localparam int FILL_BITS      = 3;
    localparam int BEATS_BITS     = 3;
    localparam int TOTAL_BITS     = 6;

    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TUSER_BITS = 2;

    // item kind carried on the input tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // up to four bytes, left aligned, plus how many of them go out
    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [BEATS_BITS-1:0] beats;
        logic                  err;
    } t_burst;

    // packer state carried from one item to the next
    typedef struct packed {
        logic [PEND_BITS-1:0] pending;
        logic [FILL_BITS-1:0] fill;
    } t_pack_state;

endpackage

// ===== sv/mbp_pack_calc.sv =====
// ----------------------------------------------------------------------------
// mbp_pack_calc
// single-pass merge of one item into the pending bits
// ----------------------------------------------------------------------------
module mbp_pack_calc (
    input  logic                           i_func,
    input  logic [mbp_pkg::COUNT_BITS-1:0] i_count,
    input  logic [mbp_pkg::VALUE_BITS-1:0] i_value,
    input  mbp_pkg::t_pack_state           i_state,
    output mbp_pkg::t_pack_state           o_state,
    output mbp_pkg::t_burst                o_burst
);
    import mbp_pkg::*;

    logic                  bad_width;
    logic [ACC_BITS-1:0]   mask;
    logic [ACC_BITS-1:0]   acc;
    logic [ACC_BITS-1:0]   acc_l;
    logic [TOTAL_BITS-1:0] total;
    logic [TOTAL_BITS-1:0] align;
    logic [PEND_BITS-1:0]  rem_mask;
    logic [14:0]           flush_sh;

    assign bad_width = (i_count == '0)
                    || (32'(i_count) > 32'(MAX_FIELD_BITS))
                    || (32'(i_count) > 32'(VALUE_BITS));

    // append the new field below the pending bits
    assign mask  = (ACC_BITS'(1) << i_count) - ACC_BITS'(1);
    assign acc   = (ACC_BITS'(i_state.pending) << i_count)
                 | (ACC_BITS'(i_value) & mask);
    assign total = TOTAL_BITS'(i_state.fill) + i_count;
    // left align so the oldest complete byte sits at the top
    assign align = TOTAL_BITS'(ACC_BITS) - total;
    assign acc_l = acc << align;

    assign rem_mask = (PEND_BITS'(1) << total[FILL_BITS-1:0]) - PEND_BITS'(1);
    assign flush_sh = 15'(i_state.pending) << (4'd8 - 4'(i_state.fill));

    always_comb begin
        o_state     = i_state;
        o_burst     = '0;
        if (i_func == FUNC_FLUSH) begin
            if (i_state.fill != '0) begin
                o_burst.word  = {flush_sh[7:0], {(WORD_BITS-8){1'b0}}};
                o_burst.beats = BEATS_BITS'(1);
                o_state       = '0;
            end
        end else if (bad_width) begin
            // error beat, state untouched
            o_burst.beats = BEATS_BITS'(1);
            o_burst.err   = 1'b1;
        end else begin
            o_burst.word  = acc_l[ACC_BITS-1 -: WORD_BITS];
            o_burst.beats = total[TOTAL_BITS-1:FILL_BITS];
            o_state.pending = acc[PEND_BITS-1:0] & rem_mask;
            o_state.fill    = total[FILL_BITS-1:0];
        end
    end

endmodule

// ===== sv/mbp_beat_out.sv =====
// ----------------------------------------------------------------------------
// mbp_beat_out
// result register that plays a burst out one byte beat per cycle while the sink is ready
// ----------------------------------------------------------------------------
module mbp_beat_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  mbp_pkg::t_burst                    i_burst,
    output logic                               o_free,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata, // out_byte
    output logic [mbp_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser, // byte_valid, error
    output logic                               m_axis_tlast
);
    import mbp_pkg::*;

    logic                  r_valid;
    logic [WORD_BITS-1:0]  r_word;
    logic [BEATS_BITS-1:0] r_left;
    logic                  r_err;
    logic                  last_beat;
    logic                  take;

    assign last_beat = (r_left == BEATS_BITS'(1));
    assign take      = r_valid && m_axis_tready;
    assign o_free    = !r_valid || (take && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (take && last_beat) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_burst.word;
            r_left <= i_burst.beats;
            r_err  <= i_burst.err;
        end else if (take) begin
            r_word <= r_word << 8;
            r_left <= r_left - BEATS_BITS'(1);
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_word[WORD_BITS-1 -: 8];
    assign m_axis_tuser  = {r_err, !r_err};
    assign m_axis_tlast  = last_beat;

endmodule

// ===== sv/msb_first_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// packs 1 to 32 bit fields msb first into a byte stream
// ----------------------------------------------------------------------------
// a write beat appends the low bit_count bits of bit_value behind up to seven
// pending bits and sends every completed byte, first packed bit in bit 7; a
// flush beat pads the pending bits with zeros and sends the partial byte if
// any; a width of 0 or above 32 gives a single error beat and keeps the
// state. an input beat is merged combinationally between the input register
// and the result register, so input beats flow one per cycle as long as each
// produces at most one output beat and the output side is ready; an item that
// completes n bytes (one to four) holds the output register until all n are
// taken, and the next item waits in the input register. items that produce no
// output beat never wait on the output side beyond the burst already queued.
module msb_first_bit_packer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mbp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // bit_count, bit_value
    input  logic                               s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // out_byte
    output logic [mbp_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,  // byte_valid, error
    output logic                               m_axis_tlast
);
    import mbp_pkg::*;

    // input register
    logic                  r_in_valid;
    logic                  r_func;
    logic [COUNT_BITS-1:0] r_count;
    logic [VALUE_BITS-1:0] r_value;

    // packer state
    t_pack_state r_state;
    t_pack_state n_state;
    t_burst      burst;

    logic out_free;
    logic advance;
    logic in_take;

    // the registered beat moves on once the result register can take it
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func  <= s_axis_tuser;
            r_count <= s_axis_tdata[COUNT_BITS-1:0];
            r_value <= s_axis_tdata[COUNT_BITS +: VALUE_BITS];
        end
    end

    // merge of the item into the pending bits
    mbp_pack_calc u_calc (
        .i_func  (r_func),
        .i_count (r_count),
        .i_value (r_value),
        .i_state (r_state),
        .o_state (n_state),
        .o_burst (burst)
    );

    // bursts with no byte do not enter the result register
    mbp_beat_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance && (burst.beats != '0)),
        .i_burst       (burst),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/sv/msb_first_bit_packer_core_tb.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core_tb
// self-checking bench for the msb-first bit packer
// ----------------------------------------------------------------------------
// a queue of field and flush items feeds a clocked driver. a clocked monitor
// predicts the byte beats of every accepted item from its own copy of the
// pending bits and fill count. it compares each output beat with the oldest
// prediction. a directed list covers the field extremes, bad widths, aligned
// and unaligned flushes and value bits above the width. then random items
// follow, with random gaps on both sides and one calm stretch without gaps.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core_tb;

    import mbp_pkg::*;

    localparam int N_ITEMS    = 420;
    localparam int IDLE_PCT   = 35;
    localparam int CALM_FROM  = 200;   // items sent before the no-gap stretch
    localparam int CALM_TO    = 280;
    localparam int WDOG_LIMIT = 1000;  // cycles with no beat on either side
    localparam int TAIL_CYC   = 20;

    // one input item; hold marks an item that waits for all bytes to drain
    typedef struct {
        logic                  func;
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_BITS-1:0] value;
        bit                    hold;
    } t_field_item;

    // one predicted output beat
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       err;
        logic       last;
    } t_byte_beat;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_BITS-1:0]    s_axis_tdata  = '0;   // bit_count, bit_value
    logic                        s_axis_tuser  = 1'b0; // func
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [7:0]                  m_axis_tdata;         // out_byte
    logic [OUT_TUSER_BITS-1:0]   m_axis_tuser;         // byte_valid, error
    logic                        m_axis_tlast;

    t_field_item field_q[$];
    t_byte_beat  byte_q[$];

    // packer state as seen by the predictor
    logic [PEND_BITS-1:0] pend_bits = '0;
    logic [FILL_BITS-1:0] pend_fill = '0;

    int n_sent    = 0;
    int n_taken   = 0;
    int fail_cnt  = 0;
    int idle_cyc  = 0;

    msb_first_bit_packer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void queue_item(logic func, int count, logic [31:0] value,
                                       bit hold = 1'b0);
        t_field_item it;
        it.func  = func;
        it.count = count[COUNT_BITS-1:0];
        it.value = value;
        it.hold  = hold;
        field_q.push_back(it);
    endfunction

    function automatic void push_beat(logic [7:0] data, logic valid, logic err,
                                      logic last);
        t_byte_beat b;
        b.data  = data;
        b.valid = valid;
        b.err   = err;
        b.last  = last;
        byte_q.push_back(b);
    endfunction

    // append one field or flush to the predicted stream
    function automatic void pack_field(logic func, logic [COUNT_BITS-1:0] count,
                                       logic [VALUE_BITS-1:0] value);
        logic [ACC_BITS-1:0] acc;
        logic [ACC_BITS-1:0] keep;
        int                  total;
        int                  n;
        n = 0;
        if (func == FUNC_FLUSH) begin
            // nothing pending means already on a byte boundary
            if (pend_fill != 0) begin
                push_beat(8'({1'b0, pend_bits} << (8 - pend_fill)), 1'b1, 1'b0, 1'b1);
                pend_bits = '0;
                pend_fill = '0;
            end
        end else if (count == 0 || count > MAX_FIELD_BITS) begin
            // bad width: one error beat, state kept
            push_beat(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
            keep  = (ACC_BITS'(1) << count) - 1'b1;
            acc   = (ACC_BITS'(pend_bits) << count) | (ACC_BITS'(value) & keep);
            total = pend_fill + count;
            while (total >= 8 && n < MAX_BEATS) begin
                total -= 8;
                push_beat(8'(acc >> total), 1'b1, 1'b0, total < 8);
                n++;
            end
            keep      = (ACC_BITS'(1) << total) - 1'b1;
            pend_bits = PEND_BITS'(acc & keep);
            pend_fill = FILL_BITS'(total);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h (beat after item %0d)",
                 what, got, want, n_taken);
        fail_cnt++;
    endtask

    // driver: new beats and ready change on the falling edge
    always @(negedge i_clk) begin
        t_field_item it;
        bit          calm;
        if (i_rst_n) begin
            calm = (n_sent >= CALM_FROM && n_sent < CALM_TO);
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            // a beat still waiting for tready stays on the bus
            if (!(s_axis_tvalid && n_taken != n_sent)) begin
                if (field_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                        && !(field_q[0].hold && byte_q.size() != 0)) begin
                    it = field_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= it.func;
                    s_axis_tdata  <= {2'b00, it.value, it.count};
                    n_sent        <= n_sent + 1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check output beats first, then predict from the input beat
    always @(posedge i_clk) begin
        t_byte_beat want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    want = byte_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("out_byte", m_axis_tdata, want.data);
                    if (m_axis_tuser[0] !== want.valid)
                        report_mismatch("byte_valid", m_axis_tuser[0], want.valid);
                    if (m_axis_tuser[1] !== want.err)
                        report_mismatch("error", m_axis_tuser[1], want.err);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pack_field(s_axis_tuser, s_axis_tdata[COUNT_BITS-1:0],
                           s_axis_tdata[COUNT_BITS +: VALUE_BITS]);
                n_taken <= n_taken + 1;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
                $display("[msb_first_bit_packer_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int cnt;

        // directed: flush aligned at reset, bad widths, field extremes
        queue_item(FUNC_FLUSH, 0, 32'h0);
        queue_item(FUNC_WRITE, 0, 32'hffff_ffff);
        queue_item(FUNC_WRITE, 63, 32'h0);
        queue_item(FUNC_WRITE, 33, 32'ha5a5_a5a5);
        queue_item(FUNC_WRITE, 1, 32'h1);
        queue_item(FUNC_WRITE, 32, 32'hffff_ffff);
        queue_item(FUNC_WRITE, 32, 32'h0);
        // value bits above the width must be dropped
        queue_item(FUNC_WRITE, 3, 32'hffff_fffd);
        queue_item(FUNC_FLUSH, 63, 32'hffff_ffff);
        queue_item(FUNC_FLUSH, 0, 32'h0);
        queue_item(FUNC_WRITE, 8, 32'h0000_01a5);
        // seven bits fill nothing, the next bit completes a byte
        queue_item(FUNC_WRITE, 7, 32'h7f);
        queue_item(FUNC_WRITE, 1, 32'h0);
        queue_item(FUNC_WRITE, 7, 32'h55);
        queue_item(FUNC_WRITE, 32, 32'hdead_beef);
        queue_item(FUNC_WRITE, 9, 32'h1ff);
        queue_item(FUNC_WRITE, 0, 32'h1234_5678);
        queue_item(FUNC_WRITE, 16, 32'hbeef);
        queue_item(FUNC_FLUSH, 0, 32'h0);
        queue_item(FUNC_WRITE, 31, 32'h7fff_ffff);
        queue_item(FUNC_WRITE, 2, 32'h2);
        queue_item(FUNC_WRITE, 24, 32'h0012_3456);
        queue_item(FUNC_FLUSH, 0, 32'h0);

        // random: mostly good fields, some flushes and bad widths
        while (field_q.size() < N_ITEMS) begin
            r = $urandom_range(99);
            if (r < 25)
                cnt = $urandom_range(1, 8);
            else if (r < 60)
                cnt = $urandom_range(9, 32);
            else if (r < 80)
                cnt = $urandom_range(1, 16);
            else if (r < 88)
                cnt = $urandom_range(1) ? 0 : $urandom_range(63, 33);
            else
                cnt = $urandom_range(63);
            // every so often let the output side run dry before sending on
            queue_item(r >= 90 ? FUNC_FLUSH : FUNC_WRITE, cnt, $urandom,
                       field_q.size() % 100 == 50);
        end

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // tvalid is stable at the rising edge and drops only once the last
        // beat has been accepted
        while (field_q.size() != 0 || s_axis_tvalid || byte_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);

        if (fail_cnt == 0 && byte_q.size() == 0)
            $display("[msb_first_bit_packer_core] OK");
        else
            $display("[msb_first_bit_packer_core] ERROR");
        $finish;
    end

endmodule
